// ----- rtl/ctc_pkg.sv -----
package ctc_pkg;

   localparam int unsigned SET_W = 26;
   localparam int unsigned COUNT_W = 6;
   localparam int unsigned CHAR_W = 8;

   localparam logic [CHAR_W-1:0] TERMINUS_MARK = 8'h2D;
   localparam logic [CHAR_W-1:0] LETTER_BASE = 8'h41;
   localparam logic [CHAR_W-1:0] LETTER_COUNT = 8'd26;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

   typedef enum logic [1:0] {
      CSR_BREAK_SET    = 2'd0,
      CSR_NO_BREAK_SET = 2'd1,
      CSR_CUT_AFTER    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                last;
      logic [1:0]          tolerable_termini;
      logic [COUNT_W-1:0]  missed_cleavages;
   } result_type;

   function automatic logic in_set(input logic [SET_W-1:0] set_bits,
                                   input logic [CHAR_W-1:0] ch);
      logic [CHAR_W-1:0] n;
      logic hit;
      n = ch - LETTER_BASE;
      hit = 1'b0;
      if (ch >= LETTER_BASE && n < LETTER_COUNT) begin
         hit = set_bits[n[4:0]];
      end
      return hit;
   endfunction

   // site between left residue x and right residue y
   function automatic logic is_site(input logic [SET_W-1:0] break_bits,
                                    input logic [SET_W-1:0] no_break_bits,
                                    input logic cut_after,
                                    input logic [CHAR_W-1:0] x,
                                    input logic [CHAR_W-1:0] y);
      logic site;
      if (cut_after) begin
         site = in_set(break_bits, x) && !in_set(no_break_bits, y);
      end else begin
         site = in_set(break_bits, y) && !in_set(no_break_bits, x);
      end
      return site;
   endfunction

endpackage

// ----- rtl/cleavage_termini_counter_core.sv -----
// Peptide cleavage counter. Residues stream in one word per cycle on req_, with the
// flanking residues and first/last marks; one result word per peptide leaves on rsp_
// after its last residue, giving the tolerable termini (0..2) and the missed cleavage
// count (saturating at 63). Each residue is judged while it sits in the input register,
// and the prior-residue register and the counter are updated as it leaves; a result
// word enters the output register as its last residue leaves, then shows on rsp_. Throughput is
// one residue per cycle; only a result waiting in the output register with rsp_ready
// low stalls a further last residue. The csr_ port writes the cleavage set (index 0),
// the blocking set (index 1) and the cut-after flag (index 2); write only while no
// peptide is in flight.
module cleavage_termini_counter_core
   import ctc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_residue,
   input  logic [7:0]          req_prev_flank,
   input  logic [7:0]          req_next_flank,
   input  logic                req_first_of_peptide,
   input  logic                req_last_of_peptide,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_tolerable_termini,
   output logic [5:0]          rsp_missed_cleavages,

   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [25:0]         csr_data
);

   logic              s1_valid_ff, s1_valid_in;
   logic [CHAR_W-1:0] s1_residue_ff, s1_prev_ff, s1_next_ff;
   logic              s1_first_ff, s1_last_ff;
   logic              s1_advance, out_free, accept, load;

   logic [SET_W-1:0]  break_set_ff, no_break_set_ff;
   logic              cut_after_ff;
   result_type        result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         break_set_ff <= '0;
         no_break_set_ff <= '0;
         cut_after_ff <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_BREAK_SET:    break_set_ff <= csr_data;
            CSR_NO_BREAK_SET: no_break_set_ff <= csr_data;
            CSR_CUT_AFTER:    cut_after_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign s1_advance = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_ready = !s1_valid_ff || s1_advance;
   assign accept = req_valid && req_ready;
   assign load = s1_advance && s1_last_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_residue_ff <= req_residue;
         s1_prev_ff <= req_prev_flank;
         s1_next_ff <= req_next_flank;
         s1_first_ff <= req_first_of_peptide;
         s1_last_ff <= req_last_of_peptide;
      end
   end

   ctc_step u_step (
      .clock            (clock),
      .reset            (reset),
      .advance          (s1_advance),
      .residue          (s1_residue_ff),
      .prev_flank       (s1_prev_ff),
      .next_flank       (s1_next_ff),
      .first_of_peptide (s1_first_ff),
      .last_of_peptide  (s1_last_ff),
      .break_set        (break_set_ff),
      .no_break_set     (no_break_set_ff),
      .cut_after_break  (cut_after_ff),
      .result           (result)
   );

   ctc_out u_out (
      .clock                 (clock),
      .reset                 (reset),
      .load                  (load),
      .result                (result),
      .rsp_ready             (rsp_ready),
      .out_free              (out_free),
      .rsp_valid             (rsp_valid),
      .rsp_tolerable_termini (rsp_tolerable_termini),
      .rsp_missed_cleavages  (rsp_missed_cleavages)
   );

   a_last_waits: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_last_ff && !out_free |=> s1_valid_ff)
      else $error("last residue dropped while result word blocked");

endmodule

// ----- rtl/ctc_step.sv -----
module ctc_step
   import ctc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [CHAR_W-1:0]   residue,
   input  logic [CHAR_W-1:0]   prev_flank,
   input  logic [CHAR_W-1:0]   next_flank,
   input  logic                first_of_peptide,
   input  logic                last_of_peptide,
   input  logic [SET_W-1:0]    break_set,
   input  logic [SET_W-1:0]    no_break_set,
   input  logic                cut_after_break,
   output result_type          result
);

   logic [CHAR_W-1:0]  prior_residue_ff, prior_residue_in;
   logic [COUNT_W-1:0] missed_count_ff, missed_count_in;
   logic               nterm_ok_ff, nterm_ok_in;
   logic               site_inner, site_nterm, cterm_ok;

   always_comb begin
      site_inner = is_site(break_set, no_break_set, cut_after_break,
                           prior_residue_ff, residue);
      site_nterm = is_site(break_set, no_break_set, cut_after_break,
                           prev_flank, residue);
      cterm_ok = (next_flank == TERMINUS_MARK) ||
                 is_site(break_set, no_break_set, cut_after_break,
                         residue, next_flank);

      prior_residue_in = residue;
      if (first_of_peptide) begin
         missed_count_in = '0;
         nterm_ok_in = (prev_flank == TERMINUS_MARK) || site_nterm;
      end else begin
         nterm_ok_in = nterm_ok_ff;
         if (site_inner && missed_count_ff != COUNT_MAX) begin
            missed_count_in = missed_count_ff + 1'b1;
         end else begin
            missed_count_in = missed_count_ff;
         end
      end

      result.last = last_of_peptide;
      result.tolerable_termini = {1'b0, nterm_ok_in} + {1'b0, cterm_ok};
      result.missed_cleavages = missed_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prior_residue_ff <= '0;
         missed_count_ff <= '0;
         nterm_ok_ff <= 1'b0;
      end else if (advance) begin
         prior_residue_ff <= prior_residue_in;
         missed_count_ff <= missed_count_in;
         nterm_ok_ff <= nterm_ok_in;
      end
   end

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      !reset && advance && !first_of_peptide |=> missed_count_ff >= $past(missed_count_ff))
      else $error("missed count went down inside a peptide");

   a_first_clears: assert property (@(posedge clock) disable iff (reset)
      !reset && advance && first_of_peptide |=> missed_count_ff == '0)
      else $error("missed count not cleared on first residue");

   a_termini_range: assert property (@(posedge clock) disable iff (reset)
      advance |-> result.tolerable_termini != 2'd3)
      else $error("tolerable termini out of range");

endmodule

// ----- rtl/ctc_out.sv -----
module ctc_out
   import ctc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  result_type          result,
   input  logic                rsp_ready,
   output logic                out_free,
   output logic                rsp_valid,
   output logic [1:0]          rsp_tolerable_termini,
   output logic [COUNT_W-1:0]  rsp_missed_cleavages
);

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         termini_ff;
   logic [COUNT_W-1:0] missed_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         termini_ff <= result.tolerable_termini;
         missed_ff <= result.missed_cleavages;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_tolerable_termini = termini_ff;
   assign rsp_missed_cleavages = missed_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> out_free)
      else $error("result word overwritten before it was taken");

   a_load_only_last: assert property (@(posedge clock) disable iff (reset)
      load |-> result.last)
      else $error("result loaded for a residue that is not last");

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
   import ctc_pkg::*;

   localparam int LIMIT_CYCLES = 200000;
   localparam int DRAIN_CYCLES = 6;
   localparam int HOLD_CYCLES = 80;
   localparam int IDLE_PCT = 7;
   localparam int MAX_REPORTS = 10;
   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam logic [SET_W-1:0] ALL_LETTERS = '1;

   typedef logic [CHAR_W-1:0] char_type;
   typedef struct packed {
      logic [1:0]         termini;
      logic [COUNT_W-1:0] missed;
   } digest_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_ready;
   char_type          req_residue = '0;
   char_type          req_prev_flank = '0;
   char_type          req_next_flank = '0;
   logic              req_first_of_peptide = 1'b0;
   logic              req_last_of_peptide = 1'b0;

   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [1:0]        rsp_tolerable_termini;
   logic [5:0]        rsp_missed_cleavages;

   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_index = '0;
   logic [SET_W-1:0]  csr_data = '0;

   // predictor state
   logic [SET_W-1:0]   break_mask = '0;
   logic [SET_W-1:0]   block_mask = '0;
   logic               cut_after = 1'b1;
   char_type           prior_res = '0;
   logic [COUNT_W-1:0] miss_count = '0;
   logic               nterm_ok = 1'b0;
   logic               cterm_ok;

   digest_type expected_digests[$];
   digest_type want;
   int      mismatches = 0;
   int      cycle_count = 0;
   bit      quiet = 1'b0;
   bit      hold_req = 1'b0;

   cleavage_termini_counter_core dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_residue           (req_residue),
      .req_prev_flank        (req_prev_flank),
      .req_next_flank        (req_next_flank),
      .req_first_of_peptide  (req_first_of_peptide),
      .req_last_of_peptide   (req_last_of_peptide),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_tolerable_termini (rsp_tolerable_termini),
      .rsp_missed_cleavages  (rsp_missed_cleavages),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   initial forever #2 clock = ~clock;

   function automatic logic letter_in(input logic [SET_W-1:0] mask, input char_type ch);
      char_type ofs;
      if (ch < LETTER_BASE || ch >= LETTER_BASE + LETTER_COUNT) return 1'b0;
      ofs = ch - LETTER_BASE;
      return mask[ofs[4:0]];
   endfunction

   // cleavage between left residue x and right residue y
   function automatic logic cleaves(input char_type x, input char_type y);
      if (cut_after) return letter_in(break_mask, x) && !letter_in(block_mask, y);
      return letter_in(break_mask, y) && !letter_in(block_mask, x);
   endfunction

   function automatic logic [SET_W-1:0] mask_of(input string letters);
      logic [SET_W-1:0] m;
      char_type ofs;
      m = '0;
      for (int i = 0; i < letters.len(); i++) begin
         ofs = char_type'(letters[i]) - LETTER_BASE;
         m[ofs[4:0]] = 1'b1;
      end
      return m;
   endfunction

   function automatic char_type pick_residue();
      int r;
      r = $urandom_range(99);
      if (r < 75) return char_type'(LETTER_BASE + $urandom_range(25));
      if (r < 85) return char_type'("a" + $urandom_range(25));
      if (r < 90) return TERMINUS_MARK;
      return char_type'($urandom_range(255));
   endfunction

   function automatic char_type pick_flank();
      int r;
      r = $urandom_range(99);
      if (r < 25) return TERMINUS_MARK;
      if (r < 85) return char_type'(LETTER_BASE + $urandom_range(25));
      return char_type'($urandom_range(255));
   endfunction

   task automatic note_mismatch(input string field, input int exp_val, input int act_val);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("mismatch on %s: expected %0d, got %0d", field, exp_val, act_val);
      end
   endtask

   // predict on each accepted word, check each result word
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BREAK_SET: break_mask = csr_data;
               CSR_NO_BREAK_SET: block_mask = csr_data;
               CSR_CUT_AFTER: cut_after = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_first_of_peptide) begin
               miss_count = '0;
               nterm_ok = (req_prev_flank == TERMINUS_MARK) ||
                          cleaves(req_prev_flank, req_residue);
            end else if (cleaves(prior_res, req_residue) && miss_count != COUNT_MAX) begin
               miss_count = miss_count + 1'b1;
            end
            prior_res = req_residue;
            if (req_last_of_peptide) begin
               cterm_ok = (req_next_flank == TERMINUS_MARK) ||
                          cleaves(req_residue, req_next_flank);
               expected_digests.push_back('{termini: {1'b0, nterm_ok} + {1'b0, cterm_ok},
                                            missed: miss_count});
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_digests.size() == 0) begin
               note_mismatch("unexpected result word, termini", -1,
                             int'(rsp_tolerable_termini));
            end else begin
               want = expected_digests.pop_front();
               if (rsp_tolerable_termini !== want.termini)
                  note_mismatch("tolerable_termini", int'(want.termini),
                                int'(rsp_tolerable_termini));
               if (rsp_missed_cleavages !== want.missed)
                  note_mismatch("missed_cleavages", int'(want.missed),
                                int'(rsp_missed_cleavages));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   // receiver: random stalls, quiet stretches, long hold-off on request
   initial forever begin
      @(negedge clock);
      if (hold_req) begin
         for (int k = 0; k < HOLD_CYCLES; k++) begin
            rsp_ready <= 1'b0;
            @(negedge clock);
         end
         hold_req = 1'b0;
      end else begin
         rsp_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   task automatic send_residue(input char_type res, input char_type prev_f,
                               input char_type next_f,
                               input logic is_first, input logic is_last);
      @(negedge clock);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_residue <= res;
      req_prev_flank <= prev_f;
      req_next_flank <= next_f;
      req_first_of_peptide <= is_first;
      req_last_of_peptide <= is_last;
      do @(posedge clock); while (!req_ready);
   endtask

   // flanks that do not matter on an item get random values
   task automatic send_peptide(input char_type seq[$], input char_type prev_f,
                               input char_type next_f);
      int n;
      n = seq.size();
      for (int i = 0; i < n; i++) begin
         send_residue(seq[i], (i == 0) ? prev_f : char_type'($urandom_range(255)),
                      (i == n - 1) ? next_f : char_type'($urandom_range(255)),
                      i == 0, i == n - 1);
      end
   endtask

   task automatic send_text(input string s, input char_type prev_f, input char_type next_f);
      char_type seq[$];
      for (int i = 0; i < s.len(); i++) seq.push_back(s[i]);
      send_peptide(seq, prev_f, next_f);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_digests.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [SET_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_enzyme(input logic [SET_W-1:0] brk, input logic [SET_W-1:0] blk,
                             input logic [SET_W-1:0] cut_word);
      wait_idle();
      write_csr(CSR_BREAK_SET, brk);
      write_csr(CSR_NO_BREAK_SET, blk);
      write_csr(CSR_CUT_AFTER, cut_word);
   endtask

   task automatic random_peptides(input int n_words);
      int sent;
      int len;
      char_type seq[$];
      sent = 0;
      while (sent < n_words) begin
         if ($urandom_range(99) < 88) begin
            len = ($urandom_range(99) < 5) ? $urandom_range(80, 30) : $urandom_range(10, 1);
            seq.delete();
            repeat (len) seq.push_back(pick_residue());
            send_peptide(seq, pick_flank(), pick_flank());
            sent += len;
         end else begin
            send_residue(char_type'($urandom_range(255)), pick_flank(), pick_flank(),
                         1'($urandom_range(1)), 1'($urandom_range(1)));
            sent++;
         end
      end
   endtask

   // reset settings; continuation word with no first mark right after reset
   task automatic test_after_reset();
      send_residue("K", "R", TERMINUS_MARK, 1'b0, 1'b1);
      send_text("A", TERMINUS_MARK, TERMINUS_MARK);
      send_text("AB", "Q", "Z");
   endtask

   task automatic test_trypsin_ends();
      set_enzyme(mask_of("KR"), mask_of("P"), 26'd1);
      send_text("PEPKRAKP", "K", TERMINUS_MARK);
      send_text("K", "R", "A");
      send_text("KkR-K", 8'h00, 8'hFF);
      send_residue(8'h00, 8'hFF, 8'h00, 1'b1, 1'b0);
      send_residue(8'hFF, "K", "@", 1'b0, 1'b0);
      send_residue("@", "K", "[", 1'b0, 1'b0);
      send_residue("[", "K", "P", 1'b0, 1'b1);
      send_residue("R", "K", "A", 1'b0, 1'b1);
   endtask

   task automatic test_cut_before();
      set_enzyme(mask_of("DZ"), mask_of("EA"), 26'h3FFFFFE);
      send_text("ADDEDZ", "E", "D");
      send_text("D", "A", TERMINUS_MARK);
      send_text("ZD", "Q", "Z");
   endtask

   task automatic test_counter_saturation();
      string s;
      set_enzyme(ALL_LETTERS, '0, 26'd1);
      s = "";
      repeat (70) s = {s, "A"};
      send_text(s, TERMINUS_MARK, "A");
   endtask

   task automatic test_random_configs();
      set_enzyme('0, '0, 26'd1);
      random_peptides(140);
      set_enzyme(ALL_LETTERS, '0, 26'd1);
      random_peptides(140);
      set_enzyme(ALL_LETTERS, ALL_LETTERS, 26'h3FFFFFE);
      random_peptides(140);
      set_enzyme(mask_of("KR"), mask_of("P"), 26'd1);
      quiet = 1'b1;
      random_peptides(140);
      quiet = 1'b0;
      set_enzyme(mask_of("DE"), mask_of("P"), 26'd0);
      random_peptides(140);
      repeat (2) begin
         set_enzyme(SET_W'($urandom), SET_W'($urandom), SET_W'($urandom));
         write_csr(CSR_SPARE, SET_W'($urandom));
         random_peptides(70);
      end
   endtask

   task automatic test_output_pressure();
      set_enzyme(mask_of("KR"), mask_of("P"), 26'd1);
      hold_req = 1'b1;
      random_peptides(60);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_after_reset();
      test_trypsin_ends();
      test_cut_before();
      test_counter_saturation();
      test_random_configs();
      test_output_pressure();
      wait_idle();
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
